// File: hw/rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the RGB 3x3 sharpen filter
// Beat layouts, pixel and window column types, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  localparam int PixBits       = 8;
  localparam int OutBits       = 12;
  localparam int KernBits      = PixBits + 4;
  localparam int NumCols       = 3;
  localparam int CfgIdxBits    = 1;
  localparam int CfgDataBits   = 13;
  localparam int CfgWidthBits  = 11;
  localparam int CfgHeightBits = 13;

  localparam logic [CfgWidthBits-1:0]  WidthReset  = CfgWidthBits'(640);
  localparam logic [CfgHeightBits-1:0] HeightReset = CfgHeightBits'(480);
  localparam logic [PixBits-1:0]       PixMax      = {PixBits{1'b1}};

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PixBits-1:0] blue;
    logic [PixBits-1:0] green;
    logic [PixBits-1:0] red;
  } pixel_t;

  // one window column: rows above, at and below the center row
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // one line buffer entry: two rows back and one row back
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_t;

  typedef struct packed {
    logic               is_pixel;
    logic [PixBits-1:0] red_in;
    logic [PixBits-1:0] green_in;
    logic [PixBits-1:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [OutBits-1:0] red_out;
    logic signed [OutBits-1:0] green_out;
    logic signed [OutBits-1:0] blue_out;
    logic                      row_end;
    logic                      frame_end;
    logic                      last_in_run;
  } out_beat_t;

  // taps handed to the kernel
  typedef struct packed {
    pixel_t lft;
    pixel_t ctr;
    pixel_t rgt;
    pixel_t top;
    pixel_t bot;
  } taps_t;

endpackage

`default_nettype wire

// File: hw/rtl/rss_line_mem.sv
// ----------------------------------------------------------------------------
// rss_line_mem: line buffer for the two previous rows
// One write port, one registered read port; a same-cycle write to the read entry is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_line_mem #(
  parameter int Depth = 1024,
  parameter int AddrBits = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  re_i,
  input  wire logic [AddrBits-1:0]   raddr_i,
  output      rss_pkg::line_t        rdata_o,
  input  wire logic                  we_i,
  input  wire logic [AddrBits-1:0]   waddr_i,
  input  wire rss_pkg::line_t        wdata_i
);

  rss_pkg::line_t mem_q [Depth];
  rss_pkg::line_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port; a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell: one column of the 3x3 window
// Holds three pixels and takes its neighbor's column on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_cell (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire rss_pkg::column_t col_i,
  output      rss_pkg::column_t col_o
);

  rss_pkg::column_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// File: hw/rtl/rss_kernel.sv
// ----------------------------------------------------------------------------
// rss_kernel: sharpen kernel for all three colors
// Gives max pixel value minus (5*center - top - bottom - left - right) per color.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_kernel (
  input  wire rss_pkg::taps_t             taps_i,
  output      logic signed [rss_pkg::OutBits-1:0] red_o,
  output      logic signed [rss_pkg::OutBits-1:0] green_o,
  output      logic signed [rss_pkg::OutBits-1:0] blue_o
);

  localparam int KB = rss_pkg::KernBits;

  function automatic logic signed [rss_pkg::OutBits-1:0] sharpen(
    input logic [rss_pkg::PixBits-1:0] l,
    input logic [rss_pkg::PixBits-1:0] c,
    input logic [rss_pkg::PixBits-1:0] r,
    input logic [rss_pkg::PixBits-1:0] t,
    input logic [rss_pkg::PixBits-1:0] b
  );
    logic signed [KB-1:0] cx;
    logic signed [KB-1:0] sum;
    logic signed [KB-1:0] acc;
    cx  = $signed(KB'(c));
    sum = (cx <<< 2) + cx - $signed(KB'(t)) - $signed(KB'(b))
        - $signed(KB'(l)) - $signed(KB'(r));
    acc = $signed(KB'(rss_pkg::PixMax)) - sum;
    return rss_pkg::OutBits'(acc);
  endfunction

  assign red_o   = sharpen(taps_i.lft.red, taps_i.ctr.red, taps_i.rgt.red,
                           taps_i.top.red, taps_i.bot.red);
  assign green_o = sharpen(taps_i.lft.green, taps_i.ctr.green, taps_i.rgt.green,
                           taps_i.top.green, taps_i.bot.green);
  assign blue_o  = sharpen(taps_i.lft.blue, taps_i.ctr.blue, taps_i.rgt.blue,
                           taps_i.top.blue, taps_i.bot.blue);

endmodule

`default_nettype wire

// File: hw/rtl/rgb_sharpen_3x3_replicate.sv
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_replicate: streaming 3x3 RGB sharpen, edges replicated
// Line buffer, three-column window chain, kernel and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_valid_i/in_stall_o; a beat is taken
//   when valid is high and stall is low. Results leave on out_valid_o /
//   out_stall_i the same way. After the last pixel of a frame, send one beat
//   with is_pixel low per column to flush the final row; such beats in the
//   middle of a frame are consumed and ignored.
//   Image width and height are written on the cfg port (always ready) while
//   the block is idle; they reset to 640 x 480.
//   Results trail the input by one row and one pixel. A result leaves through
//   the stage-1 registers, the window cells and the output register. One input
//   beat is taken per cycle while the output keeps up; a beat at the last
//   column of a row gives two results, so the window is held while the single
//   output port passes the first of them. When out_stall_i is high the result
//   holds and the pipeline (line buffer read stage and window) freezes behind it.
//   Reset clears the counters and the pipeline; the line buffer holds no
//   reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_sharpen_3x3_replicate #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel input
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire rss_pkg::in_beat_t                 in_beat_i,
  // result output
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      rss_pkg::out_beat_t                out_beat_o,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [rss_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [rss_pkg::CfgDataBits-1:0]   cfg_data_i
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MWB = $clog2(MAX_WIDTH + 1);
  localparam int WCW = (MWB > rss_pkg::CfgWidthBits) ? MWB : rss_pkg::CfgWidthBits;
  localparam int HB  = rss_pkg::CfgHeightBits;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [rss_pkg::CfgWidthBits-1:0] width_q;
  logic [HB-1:0]                    height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rss_pkg::WidthReset;
      height_q <= rss_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      case (rss_pkg::cfg_idx_e'(cfg_index_i))
        rss_pkg::CfgImageWidth:  width_q  <= cfg_data_i[rss_pkg::CfgWidthBits-1:0];
        rss_pkg::CfgImageHeight: height_q <= cfg_data_i[HB-1:0];
        default: ;
      endcase
    end
  end

  // effective width minus one, effective height
  logic [WCW-1:0] wext, weff, wm1;
  logic [HB-1:0]  heff;

  always_comb begin
    wext = WCW'(width_q);
    if (wext == '0) begin
      weff = WCW'(1);
    end else if (wext > WCW'(MAX_WIDTH)) begin
      weff = WCW'(MAX_WIDTH);
    end else begin
      weff = wext;
    end
    wm1  = weff - WCW'(1);
    heff = (height_q == '0) ? HB'(1) : height_q;
  end

  // --------------------------------------------------------------------------
  // handshake and stage advance
  logic out_valid_q, out_free;
  logic pend_a_q, pend_b_q;
  logic s1_valid_q;
  logic adv1, adv2, accept, go, emit, shift;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv2       = !(pend_a_q || pend_b_q) || (out_free && !(pend_a_q && pend_b_q));
  assign adv1       = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  // --------------------------------------------------------------------------
  // position counters
  logic [CW-1:0] col_q;
  logic [HB-1:0] row_q, row_inc;
  logic          drain_q;
  logic          last_c, produce_c;

  assign go        = accept && (in_beat_i.is_pixel || drain_q);
  assign last_c    = WCW'(col_q) >= wm1;
  assign produce_c = drain_q || (row_q != '0);
  assign row_inc   = row_q + HB'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
    end else if (go) begin
      if (last_c) begin
        col_q <= '0;
        if (drain_q) begin
          drain_q <= 1'b0;
          row_q   <= '0;
        end else begin
          row_q <= row_inc;
          if ((row_inc >= heff) || (row_inc == '0)) begin
            drain_q <= 1'b1;
          end
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line buffer read in flight
  logic           s1_drain_q, s1_ge2_q, s1_last_q, s1_prod_q, s1_cge1_q, s1_c1_q;
  logic [CW-1:0]  s1_col_q;
  rss_pkg::pixel_t s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv1) begin
      s1_valid_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_col_q   <= col_q;
      s1_drain_q <= drain_q;
      s1_ge2_q   <= row_q >= HB'(2);
      s1_last_q  <= last_c;
      s1_prod_q  <= produce_c;
      s1_cge1_q  <= col_q != '0;
      s1_c1_q    <= col_q == CW'(1);
      s1_pix_q   <= '{blue: in_beat_i.blue_in, green: in_beat_i.green_in,
                      red: in_beat_i.red_in};
    end
  end

  // line buffer
  rss_pkg::line_t rd_line, wr_line;
  logic           mem_we;

  assign mem_we  = adv2 && s1_valid_q && !s1_drain_q;
  assign wr_line = '{upper: rd_line.middle, middle: s1_pix_q};

  rss_line_mem #(
    .Depth    (MAX_WIDTH),
    .AddrBits (CW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (go),
    .raddr_i (col_q),
    .rdata_o (rd_line),
    .we_i    (mem_we),
    .waddr_i (s1_col_q),
    .wdata_i (wr_line)
  );

  // new window column; top and bottom replicate at the frame edges
  rss_pkg::column_t new_col;

  always_comb begin
    new_col.top = s1_ge2_q ? rd_line.upper : rd_line.middle;
    new_col.mid = rd_line.middle;
    new_col.bot = s1_drain_q ? rd_line.middle : s1_pix_q;
  end

  // --------------------------------------------------------------------------
  // stage 2: window cell chain, oldest column at index 0
  rss_pkg::column_t col_in  [rss_pkg::NumCols];
  rss_pkg::column_t col_out [rss_pkg::NumCols];

  assign shift = adv2 && s1_valid_q;

  for (genvar k = 0; k < rss_pkg::NumCols; k++) begin : g_cells
    if (k == rss_pkg::NumCols - 1) begin : g_head
      assign col_in[k] = new_col;
    end else begin : g_body
      assign col_in[k] = col_out[k+1];
    end
    rss_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .col_i   (col_in[k]),
      .col_o   (col_out[k])
    );
  end

  // results still owed by the item in the window
  logic s2_c1_q, s2_cge1_q, s2_last_q, s2_drain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_a_q <= 1'b0;
      pend_b_q <= 1'b0;
    end else if (adv2) begin
      pend_a_q <= s1_valid_q && s1_prod_q && s1_cge1_q;
      pend_b_q <= s1_valid_q && s1_prod_q && s1_last_q;
    end else if (out_free && pend_a_q) begin
      pend_a_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      s2_c1_q    <= s1_c1_q;
      s2_cge1_q  <= s1_cge1_q;
      s2_last_q  <= s1_last_q;
      s2_drain_q <= s1_drain_q;
    end
  end

  // tap selection: first result centers on the middle column, the row-end
  // result centers on the newest column
  rss_pkg::taps_t taps;
  logic           res_row_end, res_frame_end, res_last;

  always_comb begin
    taps.top = col_out[1].top;
    taps.bot = col_out[1].bot;
    taps.ctr = col_out[1].mid;
    taps.rgt = col_out[2].mid;
    taps.lft = s2_c1_q ? col_out[1].mid : col_out[0].mid;
    res_row_end   = 1'b0;
    res_frame_end = 1'b0;
    res_last      = !s2_last_q;
    if (!pend_a_q) begin
      taps.top      = col_out[2].top;
      taps.bot      = col_out[2].bot;
      taps.ctr      = col_out[2].mid;
      taps.rgt      = col_out[2].mid;
      taps.lft      = s2_cge1_q ? col_out[1].mid : col_out[2].mid;
      res_row_end   = 1'b1;
      res_frame_end = s2_drain_q;
      res_last      = 1'b1;
    end
  end

  logic signed [rss_pkg::OutBits-1:0] k_red, k_green, k_blue;

  rss_kernel u_kernel (
    .taps_i  (taps),
    .red_o   (k_red),
    .green_o (k_green),
    .blue_o  (k_blue)
  );

  // --------------------------------------------------------------------------
  // output register
  rss_pkg::out_beat_t out_beat_q;

  assign emit = out_free && (pend_a_q || pend_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_beat_q <= '{red_out: k_red, green_out: k_green, blue_out: k_blue,
                      row_end: res_row_end, frame_end: res_frame_end,
                      last_in_run: res_last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RGB 3x3 sharpen filter
// Streams pixel frames and drain beats through the block, predicts every
// sharpened result in a tracker object and compares it field by field as it
// leaves. Frame geometry changes between frames and, where safe, mid-frame.
// ----------------------------------------------------------------------------
module tb;

  localparam int          MaxWidth     = 1024;
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseBeats   = 110;
  localparam int unsigned NoFrameLimit = 100_000;

  // --------------------------------------------------------------------------
  // Tracker: own copy of line stores, window and counters; queue of results due
  // --------------------------------------------------------------------------
  class sharpen_tracker;
    rss_pkg::pixel_t                    upper_line [MaxWidth];
    rss_pkg::pixel_t                    middle_line [MaxWidth];
    rss_pkg::pixel_t                    win [9];
    int unsigned                        col_cnt;
    logic [rss_pkg::CfgHeightBits-1:0]  row_cnt;
    bit                                 draining;
    logic [rss_pkg::CfgWidthBits-1:0]   width_reg;
    logic [rss_pkg::CfgHeightBits-1:0]  height_reg;
    int unsigned                        frames_done;
    int unsigned                        mismatches;
    rss_pkg::out_beat_t                 due_results [$];

    function new();
      for (int i = 0; i < MaxWidth; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col_cnt     = 0;
      row_cnt     = '0;
      draining    = 1'b0;
      width_reg   = rss_pkg::WidthReset;
      height_reg  = rss_pkg::HeightReset;
      frames_done = 0;
      mismatches  = 0;
    endfunction

    function void note_config(rss_pkg::cfg_idx_e idx,
                              logic [rss_pkg::CfgDataBits-1:0] data);
      case (idx)
        rss_pkg::CfgImageWidth:  width_reg  = data[rss_pkg::CfgWidthBits-1:0];
        rss_pkg::CfgImageHeight: height_reg = data[rss_pkg::CfgHeightBits-1:0];
        default: ;
      endcase
    endfunction

    // 255 minus (5 * center - up - down - left - right), kept to the output width
    function logic signed [rss_pkg::OutBits-1:0] sharpen(int ctr, int up, int dn,
                                                         int lf, int rt);
      int acc;
      acc = 5 * ctr - up - dn - lf - rt;
      return rss_pkg::OutBits'(int'(rss_pkg::PixMax) - acc);
    endfunction

    // window column k: top, mid, bot at 3k, 3k+1, 3k+2
    function void queue_result(int lk, int ck, int rk, bit row_end, bit frame_end, bit last);
      rss_pkg::out_beat_t r;
      r.red_out     = sharpen(win[ck*3+1].red, win[ck*3].red, win[ck*3+2].red,
                              win[lk*3+1].red, win[rk*3+1].red);
      r.green_out   = sharpen(win[ck*3+1].green, win[ck*3].green, win[ck*3+2].green,
                              win[lk*3+1].green, win[rk*3+1].green);
      r.blue_out    = sharpen(win[ck*3+1].blue, win[ck*3].blue, win[ck*3+2].blue,
                              win[lk*3+1].blue, win[rk*3+1].blue);
      r.row_end     = row_end;
      r.frame_end   = frame_end;
      r.last_in_run = last;
      due_results.push_back(r);
    endfunction

    // one accepted input beat
    function void take_pixel_beat(rss_pkg::in_beat_t b);
      int unsigned     w, h, c;
      rss_pkg::pixel_t pix, mid, up, top_px, bot_px;
      bit              last;
      w = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      // drain beat inside a frame is dropped
      if (!draining && !b.is_pixel) return;
      c = (col_cnt >= MaxWidth) ? MaxWidth - 1 : col_cnt;
      pix.red   = b.red_in;
      pix.green = b.green_in;
      pix.blue  = b.blue_in;
      mid    = middle_line[c];
      up     = upper_line[c];
      top_px = (row_cnt >= 2) ? up : mid;
      bot_px = draining ? mid : pix;
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top_px;
      win[7] = mid;
      win[8] = bot_px;
      if (!draining) begin
        upper_line[c]  = mid;
        middle_line[c] = pix;
      end
      last = (c >= w - 1);
      if (draining || row_cnt >= 1) begin
        if (c >= 1) queue_result((c == 1) ? 1 : 0, 1, 2, 1'b0, 1'b0, !last);
        if (last) queue_result((c >= 1) ? 1 : 2, 2, 2, 1'b1, draining, 1'b1);
      end
      // row and frame bookkeeping
      if (last) begin
        col_cnt = 0;
        if (draining) begin
          draining = 1'b0;
          row_cnt  = '0;
          frames_done++;
        end else begin
          row_cnt = row_cnt + 1'b1;
          if (row_cnt >= h || row_cnt == 0) draining = 1'b1;
        end
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    // one accepted output beat against the oldest prediction
    function void check_sharpened(rss_pkg::out_beat_t got);
      rss_pkg::out_beat_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b last=%0b",
                   got.red_out, got.green_out, got.blue_out,
                   got.row_end, got.frame_end, got.last_in_run);
        return;
      end
      want = due_results.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.row_end !== want.row_end ||
          got.frame_end !== want.frame_end || got.last_in_run !== want.last_in_run) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b last=%0b",
                   want.red_out, want.green_out, want.blue_out,
                   want.row_end, want.frame_end, want.last_in_run);
          $display("          got r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b last=%0b",
                   got.red_out, got.green_out, got.blue_out,
                   got.row_end, got.frame_end, got.last_in_run);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  rss_pkg::in_beat_t                in_beat = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  rss_pkg::out_beat_t               out_beat;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  rss_pkg::cfg_idx_e                cfg_index = rss_pkg::CfgImageWidth;
  logic [rss_pkg::CfgDataBits-1:0]  cfg_data = '0;

  sharpen_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned beats_sent = 0;
  bit          hold_req = 1'b0;

  rgb_sharpen_3x3_replicate #(
    .MAX_WIDTH(MaxWidth)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result monitor: stall value seen here is the one in force at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_sharpened(out_beat);
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL rgb_sharpen_3x3_replicate");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic logic [rss_pkg::PixBits-1:0] pixel_level();
    case ($urandom_range(3))
      0:       return '0;
      1:       return rss_pkg::PixMax;
      default: return rss_pkg::PixBits'($urandom_range(255));
    endcase
  endfunction

  // offer one beat, optionally after an idle gap; valid stays high afterwards
  task automatic send_beat(rss_pkg::in_beat_t b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    if (b.is_pixel || tracker.draining) beats_sent++;
    tracker.take_pixel_beat(b);
  endtask

  // stop offering, let every due result out, then let the pipeline empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(rss_pkg::cfg_idx_e idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rss_pkg::CfgDataBits'(value);
    do @(posedge clk); while (!cfg_ready);
    tracker.note_config(idx, rss_pkg::CfgDataBits'(value));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    settle_block();
    write_reg(rss_pkg::CfgImageWidth, w);
    write_reg(rss_pkg::CfgImageHeight, h);
  endtask

  // random pixels until the frame closes or max_beats are sent; some drain
  // beats land mid-frame (dropped), some pixels land in the drain row
  task automatic stream(int unsigned max_beats, int unsigned noise_pct, output bit closed);
    rss_pkg::in_beat_t b;
    int unsigned       start_frames, n;
    start_frames = tracker.frames_done;
    n = 0;
    closed = 1'b0;
    while (!closed && n < max_beats) begin
      if (tracker.draining) b.is_pixel = ($urandom_range(99) < 30);
      else b.is_pixel = ($urandom_range(99) >= noise_pct);
      b.red_in   = pixel_level();
      b.green_in = pixel_level();
      b.blue_in  = pixel_level();
      send_beat(b);
      n++;
      closed = (tracker.frames_done != start_frames);
    end
  endtask

  // one random frame, now and then with a height cut partway through
  task automatic random_frame();
    bit closed;
    if ($urandom_range(99) >= 20) begin
      set_geometry(($urandom_range(99) < 5) ? $urandom_range(13, 64) : $urandom_range(0, 12),
                   $urandom_range(0, 5));
    end
    if ($urandom_range(99) < 10) begin
      stream($urandom_range(1, 30), 5, closed);
      if (!closed) begin
        settle_block();
        write_reg(rss_pkg::CfgImageHeight, $urandom_range(0, 3));
      end
    end
    stream(NoFrameLimit, 5, closed);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rss_pkg::in_beat_t b;
    bit                closed;
    int unsigned       goal;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: red checkerboard, green inverse gives both output extremes
    write_reg(rss_pkg::CfgImageWidth, 3);
    write_reg(rss_pkg::CfgImageHeight, 3);
    for (int i = 0; i < 9; i++) begin
      b.is_pixel = 1'b1;
      b.red_in   = (i % 2 == 1) ? rss_pkg::PixMax : '0;
      b.green_in = (i % 2 == 1) ? '0 : rss_pkg::PixMax;
      b.blue_in  = rss_pkg::PixBits'(i * 29);
      send_beat(b);
      if (i == 4) begin
        b.is_pixel = 1'b0;
        send_beat(b);
      end
    end
    // drain row, middle beat flagged as a pixel
    for (int j = 0; j < 3; j++) begin
      b.is_pixel = (j == 1);
      b.red_in   = pixel_level();
      b.green_in = pixel_level();
      b.blue_in  = pixel_level();
      send_beat(b);
    end

    // single-pixel frame, then zero geometry which acts as 1 x 1
    set_geometry(1, 1);
    b = '{is_pixel: 1'b1, red_in: rss_pkg::PixMax, green_in: '0, blue_in: 8'h5A};
    send_beat(b);
    b.is_pixel = 1'b0;
    send_beat(b);
    set_geometry(0, 0);
    b = '{is_pixel: 1'b1, red_in: '0, green_in: rss_pkg::PixMax, blue_in: 8'hA5};
    send_beat(b);
    b.is_pixel = 1'b0;
    send_beat(b);

    for (int ph = 0; ph < 4; ph++) begin
      settle_block();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase

      case (ph)
        0: begin
          // width beyond the line store, then cut back to a short row mid-row
          set_geometry(2047, 1);
          stream(6, 0, closed);
          settle_block();
          write_reg(rss_pkg::CfgImageWidth, 4);
          stream(NoFrameLimit, 0, closed);
          // long output hold-off while input keeps coming
          set_geometry(12, 5);
          hold_req = 1'b1;
          stream(NoFrameLimit, 0, closed);
        end
        1: begin
          // tallest height, then cut below the current row mid-frame
          set_geometry(2, 8191);
          stream(6, 0, closed);
          settle_block();
          write_reg(rss_pkg::CfgImageHeight, 2);
          stream(NoFrameLimit, 0, closed);
        end
        2: begin
          // narrower width mid-frame ends the current row early
          set_geometry(8, 4);
          stream(14, 0, closed);
          settle_block();
          write_reg(rss_pkg::CfgImageWidth, 3);
          stream(NoFrameLimit, 0, closed);
        end
        default: ;
      endcase
      set_geometry($urandom_range(1, 12), $urandom_range(1, 5));

      goal = beats_sent + PhaseBeats;
      while (beats_sent < goal) random_frame();
    end

    settle_block();
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("PASS rgb_sharpen_3x3_replicate");
    end else begin
      $display("FAIL rgb_sharpen_3x3_replicate");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rss_pkg.sv
hw/rtl/rss_line_mem.sv
hw/rtl/rss_cell.sv
hw/rtl/rss_kernel.sv
hw/rtl/rgb_sharpen_3x3_replicate.sv
test/tb.sv
